// ===== rtl/core/ips_pkg.sv =====
// ----------------------------------------------------------------------------
// Irrigation pump sequencer package
// Shared types, register indexes, command codes and reset constants.
// ----------------------------------------------------------------------------
package ips_pkg;

	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int MOIST_W   = 10;
	localparam int CMD_W     = 2;
	localparam int SUM_W     = CFG_W + 2;

	// Watering is wanted below 0.90 of the target, compared as a ratio.
	localparam int MOIST_NUM = 9;
	localparam int MOIST_DEN = 10;
	localparam int PROD_W    = MOIST_W + 4;

	localparam logic [CFG_W-1:0] CHECK_INTERVAL_RST = 24'd1000;
	localparam logic [CFG_W-1:0] PUMP_DURATION_RST  = 24'd5000;
	localparam logic [CFG_W-1:0] FERT_INTERVAL_RST  = 24'd60000;
	localparam logic [CFG_W-1:0] FERT_DURATION_RST  = 24'd3500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHECK_INTERVAL = 2'd0,
		REG_PUMP_DURATION  = 2'd1,
		REG_FERT_INTERVAL  = 2'd2,
		REG_FERT_DURATION  = 2'd3
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK       = 2'd0,
		CMD_CALIBRATE  = 2'd1,
		CMD_TEST_WATER = 2'd2,
		CMD_TEST_FERT  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [CFG_W-1:0] check_interval_ms;
		logic [CFG_W-1:0] pump_duration_ms;
		logic [CFG_W-1:0] fert_interval_ms;
		logic [CFG_W-1:0] fert_duration_ms;
	} cfg_t;

	typedef struct packed {
		logic [MOIST_W-1:0] moisture;
		logic               water_tank_low;
		logic               fert_tank_low;
		logic [CMD_W-1:0]   command;
	} item_t;

	typedef struct packed {
		logic fert;
		logic mix;
		logic water;
	} pumps_t;

	typedef struct packed {
		logic [MOIST_W-1:0] target;
		logic               testing_water;
		logic               testing_fert;
		pumps_t             pumps;
	} ctrl_t;

endpackage

// ===== rtl/core/ips_if.sv =====
// ----------------------------------------------------------------------------
// Irrigation pump sequencer channels
// Valid/ready channels for tick items and for pump state results.
// ----------------------------------------------------------------------------
interface ips_in_if;
	logic                        valid;
	logic                        ready;
	logic [ips_pkg::MOIST_W-1:0] moisture;
	logic                        water_tank_low;
	logic                        fert_tank_low;
	logic [ips_pkg::CMD_W-1:0]   command;

	modport source(output valid, output moisture, output water_tank_low,
		output fert_tank_low, output command, input ready);
	modport sink(input valid, input moisture, input water_tank_low,
		input fert_tank_low, input command, output ready);
endinterface

interface ips_out_if;
	logic valid;
	logic ready;
	logic water_pump_on;
	logic mix_pump_on;
	logic fert_pump_on;

	modport source(output valid, output water_pump_on, output mix_pump_on,
		output fert_pump_on, input ready);
	modport sink(input valid, input water_pump_on, input mix_pump_on,
		input fert_pump_on, output ready);
endinterface

// ===== rtl/core/ips_step.sv =====
// ----------------------------------------------------------------------------
// Irrigation pump sequencer tick logic
// Computes the next sequencer state for one millisecond tick.
// ----------------------------------------------------------------------------
module ips_step #(
	parameter int TIME_BITS = 32
) (
	input  ips_pkg::cfg_t          cfg,
	input  ips_pkg::item_t         item,
	input  ips_pkg::ctrl_t         ctrl,
	input  logic [TIME_BITS-1:0]   now,
	input  logic [TIME_BITS-1:0]   fert_start,
	input  logic [TIME_BITS-1:0]   pump_start,
	input  logic [TIME_BITS-1:0]   test_start,
	output ips_pkg::ctrl_t         ctrl_nx,
	output logic [TIME_BITS-1:0]   fert_start_nx,
	output logic [TIME_BITS-1:0]   pump_start_nx,
	output logic [TIME_BITS-1:0]   test_start_nx
);
	import ips_pkg::*;

	localparam int CMP_W = (TIME_BITS > SUM_W) ? TIME_BITS : SUM_W;

	logic [TIME_BITS-1:0] d_fert_raw, d_pump_raw, d_test_raw;
	logic [CMP_W-1:0]     d_fert, d_pump, d_test;
	logic [CMP_W-1:0]     fert_iv, fert_end, fert_dur;
	logic [CMP_W-1:0]     chk_iv, water_end, mix_end, pump_dur, pump_dur2;
	logic [PROD_W-1:0]    moist_scaled, target_scaled;
	logic                 want_water;
	pumps_t               p;
	logic                 tw, tf;

	assign d_fert_raw = now - fert_start;
	assign d_pump_raw = now - pump_start;
	assign d_fert     = CMP_W'(d_fert_raw);
	assign d_pump     = CMP_W'(d_pump_raw);

	assign fert_iv   = CMP_W'(cfg.fert_interval_ms);
	assign fert_dur  = CMP_W'(cfg.fert_duration_ms);
	assign fert_end  = fert_iv + fert_dur;
	assign chk_iv    = CMP_W'(cfg.check_interval_ms);
	assign pump_dur  = CMP_W'(cfg.pump_duration_ms);
	assign pump_dur2 = pump_dur + pump_dur;
	assign water_end = chk_iv + pump_dur;
	assign mix_end   = chk_iv + pump_dur2;

	assign moist_scaled  = PROD_W'(item.moisture) * PROD_W'(MOIST_DEN);
	assign target_scaled = PROD_W'(ctrl.target) * PROD_W'(MOIST_NUM);
	assign want_water    = (moist_scaled < target_scaled) && !item.water_tank_low;

	always_comb begin
		test_start_nx = test_start;
		if (item.command inside {CMD_TEST_WATER, CMD_TEST_FERT}) begin
			test_start_nx = now;
		end
	end

	assign d_test_raw = now - test_start_nx;
	assign d_test     = CMP_W'(d_test_raw);

	always_comb begin
		p             = ctrl.pumps;
		tw            = ctrl.testing_water;
		tf            = ctrl.testing_fert;
		fert_start_nx = fert_start;
		pump_start_nx = pump_start;
		ctrl_nx       = ctrl;

		if (d_fert >= fert_iv && !item.fert_tank_low) begin
			p.fert = 1'b1;
			if (d_fert >= fert_end) begin
				p.fert        = 1'b0;
				fert_start_nx = now;
			end
		end else if (!ctrl.testing_fert) begin
			p.fert = 1'b0;
		end

		if (d_pump >= chk_iv) begin
			if (want_water) begin
				p.water = 1'b1;
				if (d_pump >= water_end) begin
					p.water = 1'b0;
					p.mix   = 1'b1;
					if (d_pump >= mix_end) begin
						p.mix         = 1'b0;
						pump_start_nx = now;
					end
				end
			end else begin
				p.water       = 1'b0;
				p.mix         = 1'b0;
				pump_start_nx = now;
			end
		end

		case (cmd_t'(item.command))
			CMD_CALIBRATE: begin
				ctrl_nx.target = item.moisture;
			end
			CMD_TEST_WATER: begin
				tw = 1'b1;
			end
			CMD_TEST_FERT: begin
				tf = 1'b1;
			end
			default: begin
			end
		endcase

		if (tw) begin
			p.water = 1'b1;
			if (d_test >= pump_dur) begin
				p.water = 1'b0;
				p.mix   = 1'b1;
				if (d_test >= pump_dur2) begin
					p.mix = 1'b0;
					tw    = 1'b0;
				end
			end
		end
		if (tf) begin
			p.fert = 1'b1;
			if (d_test >= fert_dur) begin
				p.fert = 1'b0;
				tf     = 1'b0;
			end
		end

		ctrl_nx.pumps         = p;
		ctrl_nx.testing_water = tw;
		ctrl_nx.testing_fert  = tf;
	end

endmodule

// ===== rtl/core/irrigation_pump_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// Irrigation pump sequencer core
// Runs fertilizer dosing, watering and pump tests once per millisecond tick.
// ----------------------------------------------------------------------------
// A tick's pump state is registered and offered after the tick leaves the tick register.
// Throughput: one tick per cycle while results are taken; the tick register and
// the pump state register let a new tick be taken while a result waits to be taken.
// Reset: clock, timestamps, target and test flags clear, pumps off, and
// the configuration registers return to their default values.
module irrigation_pump_sequencer_core #(
	parameter int TIME_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ips_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ips_pkg::CFG_W-1:0]        cfg_data,
	ips_in_if.sink                           in_ch,
	ips_out_if.source                        out_ch
);
	import ips_pkg::*;

	cfg_t                 cfg_q;
	item_t                item_s1;
	logic                 valid_s1;
	logic                 out_valid_q;
	logic                 advance;
	ctrl_t                ctrl_q, ctrl_nx;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] fert_start_q, pump_start_q, test_start_q;
	logic [TIME_BITS-1:0] fert_start_nx, pump_start_nx, test_start_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_interval_ms <= CHECK_INTERVAL_RST;
			cfg_q.pump_duration_ms  <= PUMP_DURATION_RST;
			cfg_q.fert_interval_ms  <= FERT_INTERVAL_RST;
			cfg_q.fert_duration_ms  <= FERT_DURATION_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CHECK_INTERVAL: cfg_q.check_interval_ms <= cfg_data;
				REG_PUMP_DURATION:  cfg_q.pump_duration_ms  <= cfg_data;
				REG_FERT_INTERVAL:  cfg_q.fert_interval_ms  <= cfg_data;
				REG_FERT_DURATION:  cfg_q.fert_duration_ms  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.moisture       <= in_ch.moisture;
			item_s1.water_tank_low <= in_ch.water_tank_low;
			item_s1.fert_tank_low  <= in_ch.fert_tank_low;
			item_s1.command        <= in_ch.command;
		end
	end

	ips_step #(
		.TIME_BITS(TIME_BITS)
	) u_step (
		.cfg           (cfg_q),
		.item          (item_s1),
		.ctrl          (ctrl_q),
		.now           (now_q),
		.fert_start    (fert_start_q),
		.pump_start    (pump_start_q),
		.test_start    (test_start_q),
		.ctrl_nx       (ctrl_nx),
		.fert_start_nx (fert_start_nx),
		.pump_start_nx (pump_start_nx),
		.test_start_nx (test_start_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q       <= '0;
			now_q        <= '0;
			fert_start_q <= '0;
			pump_start_q <= '0;
			test_start_q <= '0;
		end else if (advance) begin
			ctrl_q       <= ctrl_nx;
			now_q        <= now_q + TIME_BITS'(1);
			fert_start_q <= fert_start_nx;
			pump_start_q <= pump_start_nx;
			test_start_q <= test_start_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.water_pump_on = ctrl_q.pumps.water;
	assign out_ch.mix_pump_on   = ctrl_q.pumps.mix;
	assign out_ch.fert_pump_on  = ctrl_q.pumps.fert;

	a_clock_steps: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> now_q == $past(now_q) + TIME_BITS'(1))
		else $error("millisecond clock did not step with a tick");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(now_q) && $stable(ctrl_q) && $stable(test_start_q))
		else $error("sequencer state changed without a tick");

	a_fert_test_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ctrl_q.testing_fert) |-> $past(cmd_t'(item_s1.command) == CMD_TEST_FERT))
		else $error("fertilizer test started without its command");

	a_no_result_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !advance)
		else $error("pending result overwritten");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Irrigation pump sequencer testbench
// Drives millisecond ticks and register writes into the core, predicts the
// three pump drives of every tick and compares them with the results taken
// from the output channel, under several patterns of sender and receiver
// idling.
// ----------------------------------------------------------------------------
module testbench;

	import ips_pkg::*;

	localparam int TB_TIME_BITS   = 32;
	localparam int LIMIT_CYCLES   = 200000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int SEGMENTS       = 16;
	localparam int SEGMENT_TICKS  = 115;
	localparam int MAX_REPORTS    = 100;
	localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};

	typedef enum {TICK_ITEM, REG_WRITE, WAIT_IDLE, SET_PACING} step_kind_t;

	typedef struct {
		step_kind_t       kind;
		item_t            tick;
		reg_idx_t         reg_index;
		logic [CFG_W-1:0] reg_value;
		int               idle_pct;
		int               stall_pct;
	} plan_step_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	ips_in_if  in_ch();
	ips_out_if out_ch();

	irrigation_pump_sequencer_core #(
		.TIME_BITS(TB_TIME_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	plan_step_t tick_plan[$];
	pumps_t expected_pumps[$];

	cfg_t settings;
	logic [TB_TIME_BITS-1:0] clock_ms;
	logic [TB_TIME_BITS-1:0] fert_start;
	logic [TB_TIME_BITS-1:0] pump_start;
	logic [TB_TIME_BITS-1:0] test_begin;
	logic [MOIST_W-1:0] target_level;
	logic water_test;
	logic fert_test;
	pumps_t pumps;

	item_t offered;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;
	int errors;
	int ticks_sent;
	int results_seen;
	int reg_writes;
	int water_on_count;
	int mix_on_count;
	int fert_on_count;
	int cycle_count;

	int idle_modes[4]  = '{0, 57, 0, 12};
	int stall_modes[4] = '{0, 0, 57, 12};

	function automatic pumps_t advance_tick(item_t t);
		logic [TB_TIME_BITS-1:0] span;
		logic wet_wanted;
		span = clock_ms - fert_start;
		if (64'(span) >= 64'(settings.fert_interval_ms) && !t.fert_tank_low) begin
			pumps.fert = 1'b1;
			if (64'(span) >= 64'(settings.fert_interval_ms)
					+ 64'(settings.fert_duration_ms)) begin
				pumps.fert = 1'b0;
				fert_start = clock_ms;
			end
		end else if (!fert_test) begin
			pumps.fert = 1'b0;
		end

		span = clock_ms - pump_start;
		if (64'(span) >= 64'(settings.check_interval_ms)) begin
			wet_wanted = (64'(t.moisture) * 64'd10 < 64'(target_level) * 64'd9);
			if (wet_wanted && !t.water_tank_low) begin
				pumps.water = 1'b1;
				if (64'(span) >= 64'(settings.check_interval_ms)
						+ 64'(settings.pump_duration_ms)) begin
					pumps.water = 1'b0;
					pumps.mix = 1'b1;
					if (64'(span) >= 64'(settings.check_interval_ms)
							+ 64'd2 * 64'(settings.pump_duration_ms)) begin
						pumps.mix = 1'b0;
						pump_start = clock_ms;
					end
				end
			end else begin
				pumps.water = 1'b0;
				pumps.mix = 1'b0;
				pump_start = clock_ms;
			end
		end

		case (cmd_t'(t.command))
			CMD_CALIBRATE: begin
				target_level = t.moisture;
			end
			CMD_TEST_WATER: begin
				test_begin = clock_ms;
				water_test = 1'b1;
			end
			CMD_TEST_FERT: begin
				test_begin = clock_ms;
				fert_test = 1'b1;
			end
			default: begin
			end
		endcase

		if (water_test) begin
			span = clock_ms - test_begin;
			pumps.water = 1'b1;
			if (64'(span) >= 64'(settings.pump_duration_ms)) begin
				pumps.water = 1'b0;
				pumps.mix = 1'b1;
				if (64'(span) >= 64'd2 * 64'(settings.pump_duration_ms)) begin
					pumps.mix = 1'b0;
					water_test = 1'b0;
				end
			end
		end
		if (fert_test) begin
			span = clock_ms - test_begin;
			pumps.fert = 1'b1;
			if (64'(span) >= 64'(settings.fert_duration_ms)) begin
				pumps.fert = 1'b0;
				fert_test = 1'b0;
			end
		end

		clock_ms = clock_ms + 1'b1;
		return pumps;
	endfunction

	task automatic plan_tick(int moisture, bit water_low, bit fert_low, cmd_t cmd);
		plan_step_t s;
		s.kind = TICK_ITEM;
		s.tick.moisture = MOIST_W'(moisture);
		s.tick.water_tank_low = water_low;
		s.tick.fert_tank_low = fert_low;
		s.tick.command = cmd;
		tick_plan.push_back(s);
	endtask

	task automatic plan_wait_idle();
		plan_step_t s;
		s.kind = WAIT_IDLE;
		tick_plan.push_back(s);
	endtask

	task automatic plan_register(reg_idx_t idx, logic [CFG_W-1:0] value);
		plan_step_t s;
		plan_wait_idle();
		s.kind = REG_WRITE;
		s.reg_index = idx;
		s.reg_value = value;
		tick_plan.push_back(s);
	endtask

	task automatic plan_pacing(int mode);
		plan_step_t s;
		s.kind = SET_PACING;
		s.idle_pct = idle_modes[mode];
		s.stall_pct = stall_modes[mode];
		tick_plan.push_back(s);
	endtask

	function automatic logic [CFG_W-1:0] pick_setting(int short_max);
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 10)
			return CFG_MAX;
		if (r < 16)
			return CFG_W'($urandom);
		return CFG_W'($urandom_range(1, short_max));
	endfunction

	task automatic check_field(string name, logic want, logic got);
		if (want !== got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s expected %b, actual %b", $time, name, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int r;
		int c;
		int moisture;
		cmd_t cmd;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.moisture = '0;
		in_ch.water_tank_low = 1'b0;
		in_ch.fert_tank_low = 1'b0;
		in_ch.command = '0;
		out_ch.ready = 1'b0;

		settings.check_interval_ms = CHECK_INTERVAL_RST;
		settings.pump_duration_ms = PUMP_DURATION_RST;
		settings.fert_interval_ms = FERT_INTERVAL_RST;
		settings.fert_duration_ms = FERT_DURATION_RST;
		clock_ms = '0;
		fert_start = '0;
		pump_start = '0;
		test_begin = '0;
		target_level = '0;
		water_test = 1'b0;
		fert_test = 1'b0;
		pumps = '0;
		idle_pct = 0;
		stall_pct = 0;

		// Reset defaults first, then zero registers with a pump duration of 1, then all-maximum ones.
		plan_pacing(0);
		plan_tick(0, 0, 0, CMD_TICK);
		plan_tick(1023, 1, 1, CMD_TICK);
		plan_tick(1023, 0, 0, CMD_CALIBRATE);
		plan_tick(0, 1, 0, CMD_TICK);
		plan_tick(0, 0, 0, CMD_TEST_WATER);
		plan_tick(512, 0, 1, CMD_TEST_FERT);
		plan_tick(0, 0, 0, CMD_TICK);
		plan_register(REG_CHECK_INTERVAL, '0);
		plan_register(REG_PUMP_DURATION, CFG_W'(1));
		plan_register(REG_FERT_INTERVAL, '0);
		plan_register(REG_FERT_DURATION, '0);
		plan_tick(0, 0, 0, CMD_TICK);
		plan_tick(0, 0, 1, CMD_TICK);
		plan_tick(920, 0, 0, CMD_TICK);
		plan_tick(921, 0, 0, CMD_TICK);
		plan_tick(0, 0, 0, CMD_TEST_FERT);
		plan_tick(0, 0, 0, CMD_TEST_WATER);
		plan_tick(0, 0, 0, CMD_TICK);
		plan_tick(0, 0, 0, CMD_TICK);
		plan_tick(0, 0, 0, CMD_CALIBRATE);
		plan_tick(0, 0, 0, CMD_TICK);
		plan_register(REG_CHECK_INTERVAL, CFG_MAX);
		plan_register(REG_PUMP_DURATION, CFG_MAX);
		plan_register(REG_FERT_INTERVAL, CFG_MAX);
		plan_register(REG_FERT_DURATION, CFG_MAX);
		plan_tick(1023, 0, 0, CMD_CALIBRATE);
		plan_tick(0, 0, 0, CMD_TEST_FERT);
		plan_tick(0, 0, 0, CMD_TEST_WATER);
		plan_tick(1023, 1, 1, CMD_TICK);

		// Mostly dry spells after a high calibration, so that watering
		// cycles run to completion; every fifth segment is plain noise.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			plan_pacing(seg % 4);
			plan_register(REG_CHECK_INTERVAL, pick_setting(15));
			plan_register(REG_PUMP_DURATION, pick_setting(12));
			plan_register(REG_FERT_INTERVAL, pick_setting(40));
			plan_register(REG_FERT_DURATION, pick_setting(10));
			plan_tick($urandom_range(600, 1023), 0, 0, CMD_CALIBRATE);
			for (int k = 0; k < SEGMENT_TICKS; k++) begin
				if (seg % 5 == 4) begin
					plan_tick($urandom_range(1023), 1'($urandom_range(1)),
						1'($urandom_range(1)), cmd_t'($urandom_range(3)));
				end else begin
					r = $urandom_range(99);
					moisture = (r < 80) ? $urandom_range(500) : $urandom_range(1023);
					c = $urandom_range(99);
					if (c < 3) begin
						cmd = CMD_TEST_WATER;
					end else if (c < 6) begin
						cmd = CMD_TEST_FERT;
					end else if (c < 8) begin
						cmd = CMD_CALIBRATE;
						moisture = $urandom_range(600, 1023);
					end else begin
						cmd = CMD_TICK;
					end
					plan_tick(moisture, $urandom_range(19) == 0, $urandom_range(14) == 0, cmd);
				end
				if (k == SEGMENT_TICKS / 2 && seg % 2 == 0)
					plan_wait_idle();
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (tick_plan.size() != 0 || in_ch.valid || expected_pumps.size() != 0);
		repeat (SETTLE_CYCLES * 2) @(posedge clk);

		if (expected_pumps.size() != 0) begin
			errors++;
			$display("%0t: %0d pump states never arrived", $time, expected_pumps.size());
		end
		$display("Checked %0d pump states from %0d ticks over %0d register writes.",
			results_seen, ticks_sent, reg_writes);
		$display("Pumps seen on: water %0d, mix %0d, fertilizer %0d; %0d mismatches.",
			water_on_count, mix_on_count, fert_on_count, errors);
		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	always @(posedge clk) begin
		logic slot_free;
		logic offer;
		logic reg_we;
		plan_step_t step;
		if (arst_n) begin
			offer = in_ch.valid;
			reg_we = 1'b0;
			slot_free = !in_ch.valid;
			if (in_ch.valid && in_ch.ready) begin
				expected_pumps.push_back(advance_tick(offered));
				ticks_sent++;
				offer = 1'b0;
				slot_free = 1'b1;
			end
			if (slot_free && tick_plan.size() != 0) begin
				step = tick_plan[0];
				case (step.kind)
					TICK_ITEM: begin
						if ($urandom_range(99) >= idle_pct) begin
							void'(tick_plan.pop_front());
							offered = step.tick;
							in_ch.moisture <= step.tick.moisture;
							in_ch.water_tank_low <= step.tick.water_tank_low;
							in_ch.fert_tank_low <= step.tick.fert_tank_low;
							in_ch.command <= step.tick.command;
							offer = 1'b1;
						end
					end
					SET_PACING: begin
						void'(tick_plan.pop_front());
						idle_pct = step.idle_pct;
						stall_pct = step.stall_pct;
					end
					WAIT_IDLE: begin
						if (expected_pumps.size() != 0) begin
							quiet_cycles = 0;
						end else if (quiet_cycles >= SETTLE_CYCLES) begin
							void'(tick_plan.pop_front());
							quiet_cycles = 0;
						end else begin
							quiet_cycles++;
						end
					end
					REG_WRITE: begin
						void'(tick_plan.pop_front());
						reg_we = 1'b1;
						cfg_index <= step.reg_index;
						cfg_data <= step.reg_value;
						reg_writes++;
						case (step.reg_index)
							REG_CHECK_INTERVAL: settings.check_interval_ms = step.reg_value;
							REG_PUMP_DURATION:  settings.pump_duration_ms = step.reg_value;
							REG_FERT_INTERVAL:  settings.fert_interval_ms = step.reg_value;
							REG_FERT_DURATION:  settings.fert_duration_ms = step.reg_value;
							default: begin
							end
						endcase
					end
					default: begin
					end
				endcase
			end
			in_ch.valid <= offer;
			cfg_we <= reg_we;
		end
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		pumps_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_pumps.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: pump state with no tick waiting, expected none, actual %b%b%b",
						$time, out_ch.water_pump_on, out_ch.mix_pump_on, out_ch.fert_pump_on);
			end else begin
				want = expected_pumps.pop_front();
				results_seen++;
				check_field("water_pump_on", want.water, out_ch.water_pump_on);
				check_field("mix_pump_on", want.mix, out_ch.mix_pump_on);
				check_field("fert_pump_on", want.fert, out_ch.fert_pump_on);
				water_on_count += int'(want.water);
				mix_on_count += int'(want.mix);
				fert_on_count += int'(want.fert);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: run stopped after %0d cycles", $time, cycle_count);
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		cycle_count = 0;
		errors = 0;
		ticks_sent = 0;
		results_seen = 0;
		reg_writes = 0;
		water_on_count = 0;
		mix_on_count = 0;
		fert_on_count = 0;
		quiet_cycles = 0;
	end

endmodule
